### rtl/knap_pkg.sv
// ----------------------------------------------------------------------------
// knap_pkg
// Shared widths and defaults for the 0/1 knapsack best-value block.
// ----------------------------------------------------------------------------
package knap_pkg;

    // Field widths of the item, result and configuration transfers.
    localparam int VALUE_W  = 16;
    localparam int WEIGHT_W = 10;
    localparam int CAP_W    = 10;
    localparam int BEST_W   = 32;

    // Default largest table index (table holds CAPACITY_MAX + 1 entries).
    localparam int CAPACITY_MAX_DEF = 1023;

endpackage

### rtl/knap_ram.sv
// ----------------------------------------------------------------------------
// knap_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module knap_ram
    import knap_pkg::*;
#(
    parameter int WIDTH = BEST_W,
    parameter int DEPTH = CAPACITY_MAX_DEF + 1,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/zero_one_knapsack_best_value.sv
// An item of weight w in 1..CAPACITY_MAX walks the table from CAPACITY_MAX down to w,
// reading and rewriting one entry per cycle; other weights leave the table unchanged.
// A last item is followed by the result read, any wait for the result register to empty,
// and a clearing pass over all CAPACITY_MAX + 1 entries.
// Throughput: one item at a time; in_stall is high until walk, result and clearing are done.
// Reset: capacity goes to 0; a clearing pass zeroes all CAPACITY_MAX + 1 entries.
// ----------------------------------------------------------------------------
// zero_one_knapsack_best_value
// 0/1 knapsack best-value table with a shared read-add-compare-write unit.
// ----------------------------------------------------------------------------
module zero_one_knapsack_best_value
    import knap_pkg::*;
#(
    parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CAP_W-1:0]    capacity,
    // Item channel.
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [VALUE_W-1:0]  item_value,
    input  logic [WEIGHT_W-1:0] item_weight,
    input  logic                last_item,
    // Result channel.
    output logic                out_valid,
    input  logic                out_stall,
    output logic [BEST_W-1:0]   best_value
);

    localparam int DEPTH = CAPACITY_MAX + 1;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CAPACITY_MAX);

    typedef enum logic [5:0]
    {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WALK   = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_READ   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     capacity_reg, capacity_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     weight_reg, weight_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic                 last_reg, last_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BEST_W-1:0]    best_reg, best_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [BEST_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr_a;
    logic [IDX_W-1:0]     ram_raddr_b;
    logic [BEST_W-1:0]    ram_rdata_a;
    logic [BEST_W-1:0]    ram_rdata_b;

    logic                 in_xfer;
    logic                 skip_item;
    logic [IDX_W-1:0]     cap_idx;
    logic [BEST_W:0]      cand_sum;
    logic [BEST_W-1:0]    cand_sat;
    logic                 cand_better;
    logic                 out_free;

    knap_ram
    #(
        .WIDTH (BEST_W),
        .DEPTH (DEPTH)
    )
    u_table
    (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (ram_waddr),
        .wr_data   (ram_wdata),
        .rd_addr_a (ram_raddr_a),
        .rd_data_a (ram_rdata_a),
        .rd_addr_b (ram_raddr_b),
        .rd_data_b (ram_rdata_b)
    );

    // Handshake outputs.
    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign best_value = best_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Items of weight zero or above the largest index leave the table unchanged.
    assign skip_item = (item_weight == '0) ||
                       (32'(item_weight) > 32'(CAPACITY_MAX));

    // Capacity is clamped to the largest table index.
    assign cap_idx = (32'(capacity_reg) > 32'(CAPACITY_MAX)) ? IDX_MAX
                                                             : IDX_W'(capacity_reg);

    // Shared unit: saturating add of the item value and compare with the current entry.
    assign cand_sum    = {1'b0, ram_rdata_b} + (BEST_W + 1)'(value_reg);
    assign cand_sat    = cand_sum[BEST_W] ? {BEST_W{1'b1}} : cand_sum[BEST_W-1:0];
    assign cand_better = cand_sat > ram_rdata_a;

    // Table port control: clearing pass writes zeros, otherwise the update stage writes.
    // The result entry stays addressed while the result waits for the output register.
    always_comb
    begin
        ram_raddr_a = cnt_reg;
        ram_raddr_b = cnt_reg - weight_reg;
        if (state_reg == S_READ || state_reg == S_RESULT)
        begin
            ram_raddr_a = cap_idx;
        end
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = pend_valid_reg && cand_better;
            ram_waddr = pend_addr_reg;
            ram_wdata = cand_sat;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        capacity_next   = capacity_reg;
        cnt_next        = cnt_reg;
        weight_next     = weight_reg;
        value_next      = value_reg;
        last_next       = last_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg;
        best_next       = best_reg;

        if (cfg_valid && cfg_ready)
        begin
            capacity_next = capacity;
        end

        // The result register empties on a completed transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                if (cnt_reg == IDX_MAX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    value_next  = item_value;
                    weight_next = IDX_W'(item_weight);
                    last_next   = last_item;
                    cnt_next    = IDX_MAX;
                    if (!skip_item)
                    begin
                        state_next = S_WALK;
                    end
                    else if (last_item)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_WALK:
            begin
                // Issue reads of entries c and c - w; the update lands in the next cycle.
                pend_valid_next = 1'b1;
                pend_addr_next  = cnt_reg;
                if (cnt_reg == weight_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = last_reg ? S_READ : S_IDLE;
            end
            S_READ:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    best_next      = ram_rdata_a;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            capacity_reg   <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            capacity_reg   <= capacity_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        weight_reg    <= weight_next;
        value_reg     <= value_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
        best_reg      <= best_next;
    end

    // A new result only follows the result read of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result raised outside the result state");

    // The walk never steps below the item weight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cnt_reg >= weight_reg))
        else $error("table walk went below the item weight");

    // The update stage only carries reads issued by the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> $past(state_reg == S_WALK))
        else $error("table update without a walk read");

endmodule
